### design/stt_pkg.sv
package stt_pkg;

	localparam int OFFSET_BITS_DEF = 16;

	localparam int KIND_W   = 5;
	localparam int VALUE_W  = 32;
	localparam int LEX_W    = 16;

	localparam logic [KIND_W-1:0] K_EOF     = 5'd0;
	localparam logic [KIND_W-1:0] K_RETURN  = 5'd1;
	localparam logic [KIND_W-1:0] K_LET     = 5'd2;
	localparam logic [KIND_W-1:0] K_IF      = 5'd3;
	localparam logic [KIND_W-1:0] K_ELSE    = 5'd4;
	localparam logic [KIND_W-1:0] K_IDENT   = 5'd5;
	localparam logic [KIND_W-1:0] K_INT     = 5'd6;
	localparam logic [KIND_W-1:0] K_LE      = 5'd7;
	localparam logic [KIND_W-1:0] K_GE      = 5'd8;
	localparam logic [KIND_W-1:0] K_EQ      = 5'd9;
	localparam logic [KIND_W-1:0] K_NE      = 5'd10;
	localparam logic [KIND_W-1:0] K_LT      = 5'd11;
	localparam logic [KIND_W-1:0] K_GT      = 5'd12;
	localparam logic [KIND_W-1:0] K_PLUS    = 5'd13;
	localparam logic [KIND_W-1:0] K_MINUS   = 5'd14;
	localparam logic [KIND_W-1:0] K_STAR    = 5'd15;
	localparam logic [KIND_W-1:0] K_SLASH   = 5'd16;
	localparam logic [KIND_W-1:0] K_ASSIGN  = 5'd17;
	localparam logic [KIND_W-1:0] K_SEMI    = 5'd18;
	localparam logic [KIND_W-1:0] K_LPAREN  = 5'd19;
	localparam logic [KIND_W-1:0] K_RPAREN  = 5'd20;
	localparam logic [KIND_W-1:0] K_LBRACE  = 5'd21;
	localparam logic [KIND_W-1:0] K_RBRACE  = 5'd22;
	localparam logic [KIND_W-1:0] K_INVALID = 5'd23;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [VALUE_W-1:0] value;
		logic [LEX_W-1:0]          offset;
		logic [LEX_W-1:0]          length;
		logic                      last;
	} token_t;

	// tokens produced by one accepted byte, flushed one first
	typedef struct packed {
		logic   va;
		token_t ta;
		logic   vb;
		token_t tb;
	} push_t;

endpackage

### design/stt_lexer.sv
module stt_lexer #(
	parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  logic [7:0]     text_byte,
	output stt_pkg::push_t push
);
	import stt_pkg::*;

	localparam logic [2:0] PK_NONE   = 3'd0;
	localparam logic [2:0] PK_IDENT  = 3'd1;
	localparam logic [2:0] PK_NUM    = 3'd2;
	localparam logic [2:0] PK_LT     = 3'd3;
	localparam logic [2:0] PK_GT     = 3'd4;
	localparam logic [2:0] PK_ASSIGN = 3'd5;
	localparam logic [2:0] PK_BANG   = 3'd6;

	localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

	logic [OFFSET_BITS-1:0] pos_q, pos_n;
	logic [2:0]             pend_q, pend_n;
	logic [OFFSET_BITS-1:0] start_q, start_n;
	logic [VALUE_W-1:0]     acc_q, acc_n;
	logic [7:0]             prefix_q [6];
	logic [7:0]             prefix_n [6];
	logic [2:0]             count_q, count_n;

	logic                   is_letter, is_digit, is_sep;
	logic [VALUE_W-1:0]     digit;
	logic                   flush_v;
	token_t                 flush_t;
	token_t                 zero_t;
	logic [OFFSET_BITS-1:0] ident_len;
	logic [KIND_W-1:0]      ident_kind;

	assign is_letter = (text_byte >= "a" && text_byte <= "z") ||
		(text_byte >= "A" && text_byte <= "Z") || text_byte == "_";
	assign is_digit  = text_byte >= "0" && text_byte <= "9";
	assign is_sep    = text_byte == " " || text_byte == 8'h09 || text_byte == 8'h0a;
	assign digit     = {28'd0, text_byte[3:0]};
	assign zero_t    = '0;
	assign ident_len = pos_q - start_q;

	always_comb begin
		ident_kind = K_IDENT;
		if (count_q == 3'd6 && {prefix_q[0], prefix_q[1], prefix_q[2], prefix_q[3],
				prefix_q[4], prefix_q[5]} == "return")
			ident_kind = K_RETURN;
		else if (count_q == 3'd3 && {prefix_q[0], prefix_q[1], prefix_q[2]} == "let")
			ident_kind = K_LET;
		else if (count_q == 3'd2 && {prefix_q[0], prefix_q[1]} == "if")
			ident_kind = K_IF;
		else if (count_q == 3'd4 && {prefix_q[0], prefix_q[1], prefix_q[2],
				prefix_q[3]} == "else")
			ident_kind = K_ELSE;
	end

	// token for whatever is pending when a run ends
	always_comb begin
		flush_v = 1'b1;
		flush_t = '0;
		unique case (pend_q)
			PK_IDENT: begin
				flush_t.kind = ident_kind;
				if (ident_kind == K_IDENT) begin
					flush_t.offset = LEX_W'(start_q);
					flush_t.length = LEX_W'(ident_len);
				end
			end
			PK_NUM: begin
				flush_t.kind  = K_INT;
				flush_t.value = acc_q;
			end
			PK_LT:     flush_t.kind = K_LT;
			PK_GT:     flush_t.kind = K_GT;
			PK_ASSIGN: flush_t.kind = K_ASSIGN;
			PK_BANG:   flush_t.kind = K_INVALID;
			default:   flush_v = 1'b0;
		endcase
	end

	always_comb begin
		pos_n    = pos_q;
		pend_n   = pend_q;
		start_n  = start_q;
		acc_n    = acc_q;
		count_n  = count_q;
		prefix_n = prefix_q;
		push.va  = 1'b0;
		push.ta  = zero_t;
		push.vb  = 1'b0;
		push.tb  = zero_t;
		if (fire) begin
			if (text_byte == 8'd0) begin
				push.va = flush_v;
				push.ta = flush_t;
				push.vb = 1'b1;
				push.tb.kind = K_EOF;
				pos_n   = '0;
				pend_n  = PK_NONE;
				start_n = '0;
				acc_n   = '0;
				count_n = '0;
				for (int i = 0; i < 6; i++) prefix_n[i] = '0;
			end else begin
				if (pos_q != POS_MAX) pos_n = pos_q + 1'b1;
				if (pend_q == PK_IDENT && (is_letter || is_digit)) begin
					for (int i = 0; i < 6; i++)
						if (count_q == 3'(i)) prefix_n[i] = text_byte;
					if (count_q != 3'd7) count_n = count_q + 3'd1;
				end else if (pend_q == PK_NUM && is_digit) begin
					acc_n = (acc_q << 3) + (acc_q << 1) + digit;
				end else if ((pend_q == PK_LT || pend_q == PK_GT || pend_q == PK_ASSIGN ||
						pend_q == PK_BANG) && text_byte == "=") begin
					push.vb = 1'b1;
					unique case (pend_q)
						PK_LT:     push.tb.kind = K_LE;
						PK_GT:     push.tb.kind = K_GE;
						PK_ASSIGN: push.tb.kind = K_EQ;
						default:   push.tb.kind = K_NE;
					endcase
					pend_n = PK_NONE;
				end else begin
					push.va = flush_v;
					push.ta = flush_t;
					pend_n  = PK_NONE;
					if (is_sep) begin
						pend_n = PK_NONE;
					end else if (is_letter) begin
						pend_n  = PK_IDENT;
						start_n = pos_q;
						for (int i = 1; i < 6; i++) prefix_n[i] = '0;
						prefix_n[0] = text_byte;
						count_n = 3'd1;
					end else if (is_digit) begin
						pend_n = PK_NUM;
						acc_n  = digit;
					end else begin
						push.vb = 1'b1;
						unique case (text_byte)
							"<": begin push.vb = 1'b0; pend_n = PK_LT; end
							">": begin push.vb = 1'b0; pend_n = PK_GT; end
							"=": begin push.vb = 1'b0; pend_n = PK_ASSIGN; end
							"!": begin push.vb = 1'b0; pend_n = PK_BANG; end
							"+":     push.tb.kind = K_PLUS;
							"-":     push.tb.kind = K_MINUS;
							"*":     push.tb.kind = K_STAR;
							"/":     push.tb.kind = K_SLASH;
							";":     push.tb.kind = K_SEMI;
							"(":     push.tb.kind = K_LPAREN;
							")":     push.tb.kind = K_RPAREN;
							"{":     push.tb.kind = K_LBRACE;
							"}":     push.tb.kind = K_RBRACE;
							default: push.tb.kind = K_INVALID;
						endcase
					end
				end
			end
		end
		// mark the final token of this byte
		if (push.vb) push.tb.last = 1'b1;
		else if (push.va) push.ta.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			pend_q  <= PK_NONE;
			start_q <= '0;
			acc_q   <= '0;
			count_q <= '0;
			for (int i = 0; i < 6; i++) prefix_q[i] <= '0;
		end else begin
			pos_q    <= pos_n;
			pend_q   <= pend_n;
			start_q  <= start_n;
			acc_q    <= acc_n;
			count_q  <= count_n;
			prefix_q <= prefix_n;
		end
	end

endmodule

### design/stt_token_fifo.sv
module stt_token_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  stt_pkg::push_t  push,
	output logic            space,
	output logic            token_valid,
	input  logic            token_ready,
	output stt_pkg::token_t head
);
	import stt_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	token_t          mem_q [DEPTH];
	logic [AW-1:0]   wr_q, rd_q, b_idx;
	logic [AW:0]     cnt_q, n_push;
	logic            pop;

	assign pop         = token_valid && token_ready;
	assign token_valid = cnt_q != '0;
	assign head        = mem_q[rd_q];
	// room for the two tokens one byte can make
	assign space       = cnt_q <= (AW+1)'(DEPTH - 2);
	assign b_idx       = wr_q + AW'(push.va);
	assign n_push      = (AW+1)'(push.va) + (AW+1)'(push.vb);

	always_ff @(posedge clk) begin
		if (push.va) mem_q[wr_q] <= push.ta;
		if (push.vb) mem_q[b_idx] <= push.tb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(n_push);
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + n_push - (AW+1)'(pop);
		end
	end

endmodule

### design/source_text_tokenizer.sv
// Streaming tokenizer: takes one source byte per cycle on the text channel and
// gives tokens on the token channel in source order, one per cycle while the
// consumer is ready. A byte is taken whenever the four-entry token queue has
// room for two tokens, so text flows at one byte per cycle as long as the
// consumer keeps up; a byte that ends a pending token and starts a one-character
// token makes two tokens and those drain at one per cycle. A token is written
// into the queue as the byte that completes it is taken. Byte zero flushes the
// pending token, gives EOF and returns the tokenizer to its reset state.
module source_text_tokenizer #(
	parameter int OFFSET_BITS = stt_pkg::OFFSET_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              text_valid,
	output logic                              text_ready,
	input  logic [7:0]                        text_byte,
	output logic                              token_valid,
	input  logic                              token_ready,
	output logic [stt_pkg::KIND_W-1:0]        token_kind,
	output logic signed [stt_pkg::VALUE_W-1:0] number_value,
	output logic [stt_pkg::LEX_W-1:0]         lexeme_offset,
	output logic [stt_pkg::LEX_W-1:0]         lexeme_length,
	output logic                              last_in_run
);
	import stt_pkg::*;

	push_t  push;
	token_t head;
	logic   fire;

	assign fire = text_valid && text_ready;

	stt_lexer #(.OFFSET_BITS(OFFSET_BITS)) u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.text_byte (text_byte),
		.push      (push)
	);

	stt_token_fifo u_fifo (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.space       (text_ready),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.head        (head)
	);

	assign token_kind    = head.kind;
	assign number_value  = head.value;
	assign lexeme_offset = head.offset;
	assign lexeme_length = head.length;
	assign last_in_run   = head.last;

endmodule

### design/stt_checker.sv
module stt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         token_valid,
	input logic                         token_ready,
	input logic [stt_pkg::KIND_W-1:0]   token_kind,
	input logic [stt_pkg::VALUE_W-1:0]  number_value,
	input logic [stt_pkg::LEX_W-1:0]    lexeme_offset,
	input logic [stt_pkg::LEX_W-1:0]    lexeme_length,
	input logic                         last_in_run
);
	import stt_pkg::*;

	// stalled request holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_ready |=> token_valid && $stable(token_kind))
		else $error("token changed while stalled");

	a_eof_last: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind == K_EOF |-> last_in_run)
		else $error("eof not last of its run");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind != K_INT |-> number_value == '0)
		else $error("value on non-integer token");

	a_lex_zero: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_kind != K_IDENT |-> lexeme_offset == '0 && lexeme_length == '0)
		else $error("lexeme on non-identifier token");

endmodule

bind source_text_tokenizer stt_checker u_stt_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.token_valid   (token_valid),
	.token_ready   (token_ready),
	.token_kind    (token_kind),
	.number_value  (number_value),
	.lexeme_offset (lexeme_offset),
	.lexeme_length (lexeme_length),
	.last_in_run   (last_in_run)
);

### test/source_text_tokenizer_tb.sv
module source_text_tokenizer_tb;
	import stt_pkg::*;

	localparam int POS_BITS = OFFSET_BITS_DEF;
	localparam longint unsigned POS_LIMIT = (64'd1 << POS_BITS) - 64'd1;
	localparam int CYCLE_LIMIT = 2000000;
	localparam string WORD_CHARS =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

	typedef enum logic [2:0] {
		PEND_NONE, PEND_IDENT, PEND_NUM, PEND_LT, PEND_GT, PEND_ASSIGN, PEND_BANG
	} pend_e;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        text_valid = 1'b0;
	logic                        text_ready;
	logic [7:0]                  text_byte = 8'h00;
	logic                        token_valid;
	logic                        token_ready = 1'b0;
	logic [KIND_W-1:0]           token_kind;
	logic signed [VALUE_W-1:0]   number_value;
	logic [LEX_W-1:0]            lexeme_offset;
	logic [LEX_W-1:0]            lexeme_length;
	logic                        last_in_run;

	source_text_tokenizer #(.OFFSET_BITS(POS_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text_byte(text_byte),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token_kind(token_kind),
		.number_value(number_value),
		.lexeme_offset(lexeme_offset),
		.lexeme_length(lexeme_length),
		.last_in_run(last_in_run)
	);

	always #6 clk = ~clk;

	byte unsigned    pending_text[$];
	token_t          expected_tokens[$];
	int              send_idle = 0;
	int              recv_idle = 0;
	int              errors = 0;
	int              cycle_count = 0;
	token_t          got_tok;
	token_t          want_tok;

	string keywords[4] = '{"return", "let", "if", "else"};
	string operators[17] = '{"<=", ">=", "==", "!=", "<", ">", "=", "!", "+", "-", "*",
		"/", ";", "(", ")", "{", "}"};

	// lexer state mirrored from the block
	longint unsigned text_pos = 0;
	longint unsigned ident_start = 0;
	pend_e           pend = PEND_NONE;
	logic [31:0]     num_acc = '0;
	byte unsigned    kw_prefix[6] = '{default: 8'd0};
	int              ident_len = 0;

	function automatic bit is_letter(byte unsigned c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic bit is_digit(byte unsigned c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic void clear_lexer();
		text_pos = 0;
		ident_start = 0;
		pend = PEND_NONE;
		num_acc = '0;
		kw_prefix = '{default: 8'd0};
		ident_len = 0;
	endfunction

	function automatic void push_token(logic [KIND_W-1:0] kind, logic [31:0] value,
			longint unsigned off, longint unsigned len);
		token_t t;
		t.kind = kind;
		t.value = value;
		t.offset = off[LEX_W-1:0];
		t.length = len[LEX_W-1:0];
		t.last = 1'b0;
		expected_tokens.push_back(t);
	endfunction

	function automatic void mark_last();
		token_t t;
		t = expected_tokens.pop_back();
		t.last = 1'b1;
		expected_tokens.push_back(t);
	endfunction

	function automatic bit prefix_is(string w);
		if (ident_len != w.len())
			return 1'b0;
		for (int i = 0; i < w.len(); i++)
			if (kw_prefix[i] != w[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic void flush_pending(longint unsigned here);
		case (pend)
			PEND_IDENT: begin
				if (prefix_is("return"))
					push_token(K_RETURN, 0, 0, 0);
				else if (prefix_is("let"))
					push_token(K_LET, 0, 0, 0);
				else if (prefix_is("if"))
					push_token(K_IF, 0, 0, 0);
				else if (prefix_is("else"))
					push_token(K_ELSE, 0, 0, 0);
				else
					push_token(K_IDENT, 0, ident_start, here - ident_start);
			end
			PEND_NUM:    push_token(K_INT, num_acc, 0, 0);
			PEND_LT:     push_token(K_LT, 0, 0, 0);
			PEND_GT:     push_token(K_GT, 0, 0, 0);
			PEND_ASSIGN: push_token(K_ASSIGN, 0, 0, 0);
			PEND_BANG:   push_token(K_INVALID, 0, 0, 0);
			default: ;
		endcase
	endfunction

	// tokens caused by one request, appended to expected_tokens
	function automatic void predict_tokens(byte unsigned c);
		int n_start;
		longint unsigned here;
		n_start = expected_tokens.size();
		if (c == 0) begin
			flush_pending(text_pos);
			push_token(K_EOF, 0, 0, 0);
			clear_lexer();
			mark_last();
			return;
		end
		here = text_pos;
		if (text_pos < POS_LIMIT)
			text_pos++;

		if (pend == PEND_IDENT && (is_letter(c) || is_digit(c))) begin
			if (ident_len < 6)
				kw_prefix[ident_len] = c;
			if (ident_len < 7)
				ident_len++;
			return;
		end
		if (pend == PEND_NUM && is_digit(c)) begin
			num_acc = num_acc * 32'd10 + 32'(c - "0");
			return;
		end
		if (pend inside {PEND_LT, PEND_GT, PEND_ASSIGN, PEND_BANG} && c == "=") begin
			case (pend)
				PEND_LT:     push_token(K_LE, 0, 0, 0);
				PEND_GT:     push_token(K_GE, 0, 0, 0);
				PEND_ASSIGN: push_token(K_EQ, 0, 0, 0);
				default:     push_token(K_NE, 0, 0, 0);
			endcase
			pend = PEND_NONE;
			mark_last();
			return;
		end

		flush_pending(here);
		pend = PEND_NONE;
		if (c == " " || c == "\t" || c == "\n") begin
		end else if (is_letter(c)) begin
			pend = PEND_IDENT;
			ident_start = here;
			kw_prefix = '{default: 8'd0};
			kw_prefix[0] = c;
			ident_len = 1;
		end else if (is_digit(c)) begin
			pend = PEND_NUM;
			num_acc = 32'(c - "0");
		end else begin
			case (c)
				"<": pend = PEND_LT;
				">": pend = PEND_GT;
				"=": pend = PEND_ASSIGN;
				"!": pend = PEND_BANG;
				"+": push_token(K_PLUS, 0, 0, 0);
				"-": push_token(K_MINUS, 0, 0, 0);
				"*": push_token(K_STAR, 0, 0, 0);
				"/": push_token(K_SLASH, 0, 0, 0);
				";": push_token(K_SEMI, 0, 0, 0);
				"(": push_token(K_LPAREN, 0, 0, 0);
				")": push_token(K_RPAREN, 0, 0, 0);
				"{": push_token(K_LBRACE, 0, 0, 0);
				"}": push_token(K_RBRACE, 0, 0, 0);
				default: push_token(K_INVALID, 0, 0, 0);
			endcase
		end
		if (expected_tokens.size() > n_start)
			mark_last();
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			pending_text.push_back(s[i]);
	endfunction

	function automatic byte unsigned rand_word_char(bit lead);
		return lead ? WORD_CHARS[$urandom_range(52)] : WORD_CHARS[$urandom_range(62)];
	endfunction

	function automatic void add_separator();
		case ($urandom_range(2))
			0: pending_text.push_back(" ");
			1: pending_text.push_back("\t");
			default: pending_text.push_back("\n");
		endcase
	endfunction

	// one random token, mostly well formed, some noise
	function automatic void add_random_token();
		int pick;
		int v;
		string w;
		pick = $urandom_range(99);
		if (pick < 14) begin
			w = keywords[$urandom_range(3)];
			v = $urandom_range(3);
			if (v == 0)
				w = w.substr(0, w.len() - 2);
			add_text(w);
			if (v == 1)
				pending_text.push_back(rand_word_char(0));
		end else if (pick < 36) begin
			pending_text.push_back(rand_word_char(1));
			repeat ($urandom_range(0, 11))
				pending_text.push_back(rand_word_char(0));
		end else if (pick < 56) begin
			repeat ($urandom_range(1, 12))
				pending_text.push_back(8'("0" + $urandom_range(9)));
		end else if (pick < 84) begin
			add_text(operators[$urandom_range(16)]);
		end else if (pick < 93) begin
			pending_text.push_back(8'($urandom_range(1, 255)));
		end else begin
			repeat ($urandom_range(1, 3))
				add_separator();
		end
		if ($urandom_range(99) < 55)
			add_separator();
	endfunction

	function automatic void add_random_text(int n_bytes);
		int n_start;
		n_start = pending_text.size();
		while (pending_text.size() - n_start < n_bytes) begin
			add_random_token();
			if ($urandom_range(99) < 4)
				pending_text.push_back(8'd0);
		end
		pending_text.push_back(8'd0);
	endfunction

	task automatic wait_drained();
		while (pending_text.size() != 0 || text_valid || expected_tokens.size() != 0)
			@(posedge clk);
	endtask

	// sender: one request in flight, held until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
			text_byte <= 8'h00;
		end else begin
			if (text_valid && text_ready)
				predict_tokens(text_byte);
			if (!text_valid || text_ready) begin
				if (pending_text.size() != 0 && $urandom_range(99) >= send_idle) begin
					text_valid <= 1'b1;
					text_byte <= pending_text.pop_front();
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	// receiver and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_ready <= 1'b0;
		end else begin
			if (token_valid && token_ready) begin
				got_tok.kind = token_kind;
				got_tok.value = number_value;
				got_tok.offset = lexeme_offset;
				got_tok.length = lexeme_length;
				got_tok.last = last_in_run;
				if (expected_tokens.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected token: kind %0d value %0d offset %0d length %0d last %0b",
							token_kind, number_value, lexeme_offset, lexeme_length, last_in_run);
				end else begin
					want_tok = expected_tokens.pop_front();
					if (got_tok.kind !== want_tok.kind || got_tok.value !== want_tok.value ||
							got_tok.offset !== want_tok.offset ||
							got_tok.length !== want_tok.length ||
							got_tok.last !== want_tok.last) begin
						errors++;
						if (errors <= 10) begin
							$display("token mismatch: expected kind %0d value %0d offset %0d length %0d last %0b",
								want_tok.kind, want_tok.value, want_tok.offset,
								want_tok.length, want_tok.last);
							$display("                got kind %0d value %0d offset %0d length %0d last %0b",
								got_tok.kind, got_tok.value, got_tok.offset,
								got_tok.length, got_tok.last);
						end
					end
				end
			end
			token_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		send_idle = 11;
		recv_idle = 76;
		// keywords, near-keywords, wrapping number, number then letter, operator pairs
		add_text("let if{else}return returnx _9\tx1\n4294967296a!<>=!=<=>==+-*/();");
		pending_text.push_back(8'h80);
		pending_text.push_back(8'hff);
		pending_text.push_back(8'h7f);
		pending_text.push_back(8'h01);
		pending_text.push_back(8'd0);
		// empty text, then text ending on pending tokens
		pending_text.push_back(8'd0);
		add_text("if");
		pending_text.push_back(8'd0);
		add_text("<");
		pending_text.push_back(8'd0);
		add_random_text(600);
		wait_drained();

		send_idle = 76;
		recv_idle = 11;
		add_random_text(600);
		wait_drained();

		send_idle = 0;
		recv_idle = 0;
		add_random_text(600);
		// long identifier that saturates the identifier byte count
		add_text("a + 7; ");
		pending_text.push_back(rand_word_char(1));
		repeat (40)
			pending_text.push_back(rand_word_char(0));
		add_text(" ab 12<=c;xy");
		pending_text.push_back(8'd0);
		wait_drained();

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
